>>> hdl/sopr_pkg.sv
// Shared types and constants for the serial odd-parity receiver.
// No dependencies; every other file of the block but sopr_if imports this package.
`default_nettype none

package sopr_pkg;

    // Tick counter must hold three halves of the widest bit period.
    localparam int TICK_W = 17;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_BYTES = 2'd2;
    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [15:0] BIT_PERIOD_RST    = 16'd200;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000000;
    localparam logic [7:0]  MESSAGE_BYTES_RST = 8'd1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BITS = 2'd1,
        PH_STOP = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_BYTE_OK = 2'd0,
        EV_PARITY  = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    typedef struct packed {
        logic [15:0] bit_period;
        logic [31:0] timeout_ticks;
        logic [7:0]  message_bytes;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data;
        logic [7:0]  byte_index;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/sopr_if.sv
// Valid/ready channel interfaces for line samples and receiver results.
// Standalone; used by the top level of the serial odd-parity receiver.
`default_nettype none

interface sopr_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

interface sopr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] data;
    logic [7:0] byte_index;
    logic       last;

    modport source (output valid, output event_res, output data,
                    output byte_index, output last, input ready);
    modport sink (input valid, input event_res, input data,
                  input byte_index, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/sopr_cfg.sv
// Configuration register bank of the serial odd-parity receiver.
// Depends on sopr_pkg.
`default_nettype none

module sopr_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [sopr_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [sopr_pkg::CFG_DATA_W-1:0]  i_data,
    output sopr_pkg::t_cfg                        o_cfg
);
    import sopr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period    <= BIT_PERIOD_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
            r_cfg.message_bytes <= MESSAGE_BYTES_RST;
        end else if (i_we) begin
            case (i_idx)
                CFG_BIT_PERIOD:    r_cfg.bit_period    <= i_data[15:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_data[31:0];
                CFG_MESSAGE_BYTES: r_cfg.message_bytes <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/sopr_core.sv
// Receive state machine: bit timing, byte assembly, parity and message control.
// Depends on sopr_pkg.
`default_nettype none

module sopr_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic         i_level,
    input  sopr_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output sopr_pkg::t_result o_res
);
    import sopr_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [3:0]        r_bitn, n_bitn;
    logic [7:0]        r_shift, n_shift;
    logic              r_par, n_par;
    logic [7:0]        r_bytes, n_bytes;
    logic [31:0]       r_idle, n_idle;

    logic [TICK_W:0]   triple;
    logic [TICK_W-1:0] first_len;
    logic [TICK_W-1:0] period_len;
    logic [TICK_W-1:0] tick_dec;
    logic              msg_done;

    // Delay from the start edge to the first data sample, at least one tick.
    assign triple     = {2'b00, i_cfg.bit_period} + {1'b0, i_cfg.bit_period, 1'b0};
    assign first_len  = (triple[TICK_W:1] == '0) ? TICK_W'(1) : triple[TICK_W:1];
    assign period_len = (i_cfg.bit_period == '0) ? TICK_W'(1)
                                                 : {1'b0, i_cfg.bit_period};
    assign tick_dec   = (r_tick != '0) ? r_tick - TICK_W'(1) : '0;
    assign msg_done   = ({1'b0, r_bytes} + 9'd1) >= {1'b0, i_cfg.message_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_tick  <= '0;
            r_bitn  <= '0;
            r_shift <= '0;
            r_par   <= 1'b0;
            r_bytes <= '0;
            r_idle  <= '0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bitn  <= n_bitn;
            r_shift <= n_shift;
            r_par   <= n_par;
            r_bytes <= n_bytes;
            r_idle  <= n_idle;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bitn      = r_bitn;
        n_shift     = r_shift;
        n_par       = r_par;
        n_bytes     = r_bytes;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '{event_res: EV_BYTE_OK, data: '0, byte_index: '0, last: 1'b0};

        if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    // The idle timeout wins over a start edge on the same tick.
                    if (r_bytes != '0 && r_idle >= i_cfg.timeout_ticks) begin
                        o_res_valid      = 1'b1;
                        o_res.event_res  = EV_TIMEOUT;
                        o_res.byte_index = r_bytes;
                        o_res.last       = 1'b1;
                        n_bytes          = '0;
                        n_idle           = '0;
                    end else if (!i_level) begin
                        n_phase = PH_BITS;
                        n_tick  = first_len;
                        n_bitn  = '0;
                        n_shift = '0;
                        n_par   = 1'b0;
                    end else if (r_idle != '1) begin
                        n_idle = r_idle + 32'd1;
                    end
                end
                PH_BITS: begin
                    n_tick = tick_dec;
                    if (tick_dec == '0) begin
                        n_tick = period_len;
                        if (!r_bitn[3]) begin
                            n_shift = r_shift | (8'(i_level) << r_bitn[2:0]);
                            n_par   = r_par ^ i_level;
                            n_bitn  = r_bitn + 4'd1;
                        end else begin
                            // Parity sample: data ones plus parity must be odd.
                            n_phase     = PH_STOP;
                            n_bitn      = '0;
                            o_res_valid = 1'b1;
                            if ((r_par ^ i_level) == 1'b0) begin
                                o_res.event_res  = EV_PARITY;
                                o_res.byte_index = r_bytes;
                                o_res.last       = 1'b1;
                                n_bytes          = '0;
                            end else begin
                                o_res.event_res  = EV_BYTE_OK;
                                o_res.data       = r_shift;
                                o_res.byte_index = r_bytes;
                                o_res.last       = msg_done;
                                n_bytes          = msg_done ? 8'd0 : r_bytes + 8'd1;
                            end
                        end
                    end
                end
                PH_STOP: begin
                    n_tick = tick_dec;
                    if (tick_dec == '0) begin
                        n_phase = PH_HUNT;
                        n_idle  = '0;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/sopr_out_reg.sv
// Result register between the receive logic and the result channel.
// Depends on sopr_pkg.
`default_nettype none

module sopr_out_reg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  sopr_pkg::t_result i_res,
    input  wire logic         i_ready,
    output logic              o_valid,
    output sopr_pkg::t_result o_res,
    output logic              o_can_load
);
    import sopr_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> hdl/serial_odd_parity_receiver.sv
// Serial odd-parity receiver, top level. Depends on sopr_pkg, sopr_if,
// sopr_cfg, sopr_core and sopr_out_reg.
// Throughput: one line sample per clock cycle, every cycle while the result
// side is ready or no result is held. A result is registered for the output
// channel when the sample that produces it is transferred.
// Reset (synchronous, active low) restores the register defaults and hunting.
`default_nettype none

module serial_odd_parity_receiver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    sopr_in_if.sink                               i_in,
    sopr_out_if.source                            o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [sopr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sopr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sopr_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result held_res;
    logic    core_res_valid;
    logic    can_load;
    logic    step;

    // A sample transfer advances the receiver by exactly one tick. Samples are
    // held off only while a finished result waits and the sink is not ready.
    assign i_in.ready = can_load;
    assign step       = i_in.valid && can_load;

    sopr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The state machine decides on each tick whether a byte, a parity error
    // or an idle timeout is reported.
    sopr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_level     (i_in.line_level),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // The result register separates the two channels so that a waiting result
    // does not stop sampling when the sink takes it in the same cycle.
    sopr_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (core_res_valid),
        .i_res      (core_res),
        .i_ready    (o_res.ready),
        .o_valid    (o_res.valid),
        .o_res      (held_res),
        .o_can_load (can_load)
    );

    assign o_res.event_res  = held_res.event_res;
    assign o_res.data       = held_res.data;
    assign o_res.byte_index = held_res.byte_index;
    assign o_res.last       = held_res.last;

endmodule

`default_nettype wire
